// ===== rtl/slea_pkg.sv =====
// ============================================================================
// slea_pkg
// Shared widths, codes and thresholds of the slot lift easing animator.
// ============================================================================
package slea_pkg;

    localparam int MAX_SLOTS      = 32;
    localparam int IDX_W          = $clog2(MAX_SLOTS);
    localparam int CNT_W          = IDX_W + 1;
    localparam int LIFT_FRAC_BITS = 16;
    localparam int LIFT_W         = LIFT_FRAC_BITS + 1;

    localparam logic [LIFT_W-1:0] LIFT_ONE  = LIFT_W'(1) << LIFT_FRAC_BITS;
    localparam logic [LIFT_W-1:0] LIFT_HALF = LIFT_W'(1) << (LIFT_FRAC_BITS - 1);

    // |l - want| * 500 < ONE  <=>  |l - want| < SNAP_LIMIT
    localparam int SNAP_VAL = (2 ** LIFT_FRAC_BITS + 499) / 500;
    localparam logic [LIFT_W-1:0] SNAP_LIMIT = LIFT_W'(SNAP_VAL);
    // l * 1000 > ONE  <=>  l > ANY_LIMIT
    localparam int ANY_VAL = (2 ** LIFT_FRAC_BITS) / 1000;
    localparam logic [LIFT_W-1:0] ANY_LIMIT = LIFT_W'(ANY_VAL);

    localparam int DT_W = 17;
    localparam logic [DT_W-1:0] DT_MAX_US = DT_W'(100000);
    localparam int EXP_SQUARINGS = 8;

    localparam int CFG_W     = 20;
    localparam int REG_IDX_W = 1;
    localparam logic [REG_IDX_W-1:0] REG_RISE_TAU = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_FALL_DUR = 1'b1;
    localparam logic [CFG_W-1:0] RISE_TAU_RESET = CFG_W'(60000);
    localparam logic [CFG_W-1:0] FALL_DUR_RESET = CFG_W'(150000);

    localparam int OP_W = 2;
    localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
    localparam logic [OP_W-1:0] OP_TARGET = 2'd1;
    localparam logic [OP_W-1:0] OP_FALL   = 2'd2;
    localparam logic [OP_W-1:0] OP_ROTATE = 2'd3;

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 24;

    localparam int DIV_W = 48;

endpackage

// ===== rtl/slot_lift_easing_animator_core.sv =====
// ============================================================================
// slot_lift_easing_animator_core
// Per-slot lift animator: exponential rise toward the hovered slot and a timed
// cubic ease-out fall, with the lifts kept in single-port synchronous memories.
// ============================================================================
//  channel | direction | handshake          | contents
//  s       | in        | s_tvalid/s_tready  | tuser op, tdata command fields
//  m       | out       | m_tvalid/m_tready  | tdata slot result, tlast end of tick
//  cfg     | in        | cfg_we             | register index and value
//
// The length of a rise or fall tick is set by the shared 48-step restoring divider
// and by the single lift memory port that each slot passes through twice. Begin
// fall copies the lifts of all MAX_SLOTS entries, rotate shifts the active slots
// through the memories, and set target is taken without leaving idle.
// Reset clears per-slot valid bits at once, so there is no clearing pass.
// A stalled result holds the emission loop; no command is taken until it ends.
module slot_lift_easing_animator_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // s_tdata: target_slot[5:0], forward[6], animate[7], slot_count[13:8],
    //          timestamp_us[45:14], zero pad[47:46]
    input  logic [slea_pkg::S_TDATA_W-1:0]  s_tdata,
    // s_tuser: op[1:0]
    input  logic [slea_pkg::OP_W-1:0]       s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // m_tdata: slot_index[4:0], lift[21:5], any_lift[22], falling[23]
    output logic [slea_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                            m_tlast,
    input  logic                            cfg_we,
    input  logic [slea_pkg::REG_IDX_W-1:0]  cfg_index,
    input  logic [slea_pkg::CFG_W-1:0]      cfg_wdata
);
    import slea_pkg::*;

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_COPY_RD  = 5'd1;
    localparam logic [4:0] S_COPY_WR  = 5'd2;
    localparam logic [4:0] S_ROT_LOAD = 5'd3;
    localparam logic [4:0] S_ROT_KEEP = 5'd4;
    localparam logic [4:0] S_ROT_RD   = 5'd5;
    localparam logic [4:0] S_ROT_WR   = 5'd6;
    localparam logic [4:0] S_ROT_END  = 5'd7;
    localparam logic [4:0] S_TICK     = 5'd8;
    localparam logic [4:0] S_TDIV     = 5'd9;
    localparam logic [4:0] S_S2       = 5'd10;
    localparam logic [4:0] S_S2W      = 5'd11;
    localparam logic [4:0] S_S3       = 5'd12;
    localparam logic [4:0] S_S3W      = 5'd13;
    localparam logic [4:0] S_UDIV     = 5'd14;
    localparam logic [4:0] S_U2       = 5'd15;
    localparam logic [4:0] S_U2W      = 5'd16;
    localparam logic [4:0] S_U3       = 5'd17;
    localparam logic [4:0] S_U3W      = 5'd18;
    localparam logic [4:0] S_QDIV     = 5'd19;
    localparam logic [4:0] S_SQ       = 5'd20;
    localparam logic [4:0] S_SQW      = 5'd21;
    localparam logic [4:0] S_SLOT_RD  = 5'd22;
    localparam logic [4:0] S_SLOT_MUL = 5'd23;
    localparam logic [4:0] S_SLOT_WR  = 5'd24;
    localparam logic [4:0] S_EMIT_RD  = 5'd25;
    localparam logic [4:0] S_EMIT_WR  = 5'd26;

    localparam int DIVQ_W = 6;

    // floor(x / 6) equals (x * RECIP_6) >> 34 for every 32-bit x.
    localparam logic [31:0] RECIP_6 = 32'hAAAA_AAAB;

    // Command fields
    logic signed [5:0] in_target;
    logic              in_forward;
    logic              in_animate;
    logic [CNT_W-1:0]  in_count;
    logic [31:0]       in_now;
    logic [CNT_W-1:0]  in_count_clamp;

    assign in_target  = s_tdata[5:0];
    assign in_forward = s_tdata[6];
    assign in_animate = s_tdata[7];
    assign in_count   = s_tdata[13:8];
    assign in_now     = s_tdata[45:14];
    assign in_count_clamp = (in_count > CNT_W'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS) : in_count;

    // Registers and next values
    logic [4:0]          state_reg, state_next;
    logic [CFG_W-1:0]    tau_reg, tau_next, dur_reg, dur_next;
    logic [5:0]          hover_reg, hover_next;
    logic [CNT_W-1:0]    active_reg, active_next;
    logic                any_raised_reg, any_raised_next;
    logic                fall_reg, fall_next;
    logic [31:0]         fall_start_reg, fall_start_next;
    logic [31:0]         prev_reg, prev_next;
    logic                seen_reg, seen_next;
    logic [MAX_SLOTS-1:0] valid_reg, valid_next;
    logic [31:0]         now_reg, now_next;
    logic                anim_reg, anim_next;
    logic                fwd_reg, fwd_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [DT_W-1:0]     dt_reg, dt_next;
    logic [LIFT_W-1:0]   t_reg, t_next;
    logic [LIFT_W-1:0]   s3_reg, s3_next;
    logic [31:0]         u_reg, u_next, u2_reg, u2_next, e_reg, e_next;
    logic [LIFT_W-1:0]   k_reg, k_next;
    logic [2:0]          sq_cnt_reg, sq_cnt_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic                any_acc_reg, any_acc_next;
    logic [LIFT_W-1:0]   l_reg, l_next;
    logic [LIFT_W-1:0]   keep_l_reg, keep_l_next, keep_o_reg, keep_o_next;
    logic                m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0] m_data_reg, m_data_next;
    logic                m_last_reg, m_last_next;

    // Divider
    logic                div_start;
    logic [DIV_W-1:0]    div_num;
    logic [CFG_W-1:0]    div_den;
    logic [CFG_W-1:0]    div_rem_reg, div_rem_next;
    logic [DIV_W-1:0]    div_quo_reg, div_quo_next;
    logic [CFG_W-1:0]    div_den_reg;
    logic [DIVQ_W-1:0]   div_cnt_reg;
    logic                div_busy_reg;
    logic [CFG_W:0]      div_shift;
    logic                div_ge;

    // Multiplier
    logic [31:0]         mul_a, mul_b;
    logic [63:0]         mul_p_reg;

    // Memories
    logic [LIFT_W-1:0]   lift_mem [MAX_SLOTS];
    logic [LIFT_W-1:0]   orig_mem [MAX_SLOTS];
    logic                rd_en;
    logic [IDX_W-1:0]    rd_addr;
    logic                lift_we, orig_we;
    logic [IDX_W-1:0]    wr_addr;
    logic [LIFT_W-1:0]   lift_wd, orig_wd;
    logic [LIFT_W-1:0]   lift_q_reg, orig_q_reg;
    logic                lift_qv_reg;
    logic                valid_clear;

    // Datapath helpers
    logic [LIFT_W-1:0]   lv;
    logic [31:0]         tick_diff, el;
    logic [24:0]         tau_x24;
    logic                hit;
    logic [LIFT_W-1:0]   want, rise_diff, step_m;
    logic [40:0]         rnd_sum;
    logic [LIFT_W-1:0]   r_l, r_d, rise_final, fall_final, slot_l;
    logic                slot_any;
    logic [63:0]         sq_sum;
    logic [31:0]         e_new;
    logic [32:0]         k_one_minus;
    logic [48:0]         k_sum;
    logic [33:0]         e_init;
    logic [CNT_W-1:0]    idx_inc, rot_end, rot_src;
    logic [LIFT_W-1:0]   s_val;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    assign lv        = lift_qv_reg ? lift_q_reg : '0;
    assign tick_diff = in_now - prev_reg;
    assign el        = now_reg - fall_start_reg;
    assign tau_x24   = ({5'd0, tau_reg} << 4) + ({5'd0, tau_reg} << 3);
    assign hit       = !hover_reg[5] && (idx_reg[IDX_W-1:0] == hover_reg[IDX_W-1:0]);
    assign want      = hit ? LIFT_ONE : '0;
    assign rise_diff = (want >= lv) ? want - lv : lv - want;
    assign rnd_sum   = mul_p_reg[40:0] + 41'(LIFT_HALF);
    assign step_m    = rnd_sum[LIFT_FRAC_BITS +: LIFT_W];
    assign r_l       = (want >= l_reg) ? l_reg + step_m : l_reg - step_m;
    assign r_d       = (want >= r_l) ? want - r_l : r_l - want;
    assign rise_final = (r_d < SNAP_LIMIT) ? want : r_l;
    assign fall_final = (step_m < SNAP_LIMIT) ? '0 : step_m;
    assign slot_l    = fall_reg ? fall_final : rise_final;
    assign slot_any  = slot_l > ANY_LIMIT;
    assign sq_sum    = mul_p_reg + 64'h0000_0000_8000_0000;
    assign e_new     = sq_sum[63:32];
    assign k_one_minus = 33'h1_0000_0000 - {1'b0, e_new};
    assign k_sum     = {k_one_minus, 16'd0} + 49'h0_0000_8000_0000;
    assign e_init    = 34'h1_0000_0000 - {2'b0, u_reg} + {3'b0, u2_reg[31:1]}
                       - {4'b0, mul_p_reg[63:34]};
    assign idx_inc   = idx_reg + CNT_W'(1);
    assign rot_end   = fwd_reg ? active_reg - CNT_W'(1) : '0;
    assign rot_src   = fwd_reg ? idx_reg + CNT_W'(1) : idx_reg - CNT_W'(1);
    assign s_val     = LIFT_ONE - t_reg;

    // One quotient bit per cycle
    assign div_shift    = {div_rem_reg, div_quo_reg[DIV_W-1]};
    assign div_ge       = div_shift >= {1'b0, div_den_reg};
    assign div_rem_next = div_ge ? CFG_W'(div_shift - {1'b0, div_den_reg})
                                 : div_shift[CFG_W-1:0];
    assign div_quo_next = {div_quo_reg[DIV_W-2:0], div_ge};

    always_comb
    begin
        state_next      = state_reg;
        tau_next        = tau_reg;
        dur_next        = dur_reg;
        hover_next      = hover_reg;
        active_next     = active_reg;
        any_raised_next = any_raised_reg;
        fall_next       = fall_reg;
        fall_start_next = fall_start_reg;
        prev_next       = prev_reg;
        seen_next       = seen_reg;
        now_next        = now_reg;
        anim_next       = anim_reg;
        fwd_next        = fwd_reg;
        count_next      = count_reg;
        dt_next         = dt_reg;
        t_next          = t_reg;
        s3_next         = s3_reg;
        u_next          = u_reg;
        u2_next         = u2_reg;
        e_next          = e_reg;
        k_next          = k_reg;
        sq_cnt_next     = sq_cnt_reg;
        idx_next        = idx_reg;
        any_acc_next    = any_acc_reg;
        l_next          = l_reg;
        keep_l_next     = keep_l_reg;
        keep_o_next     = keep_o_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_data_next     = m_data_reg;
        m_last_next     = m_last_reg;
        div_start       = 1'b0;
        div_num         = '0;
        div_den         = '0;
        mul_a           = '0;
        mul_b           = '0;
        rd_en           = 1'b0;
        rd_addr         = idx_reg[IDX_W-1:0];
        lift_we         = 1'b0;
        orig_we         = 1'b0;
        wr_addr         = idx_reg[IDX_W-1:0];
        lift_wd         = lv;
        orig_wd         = orig_q_reg;
        valid_clear     = 1'b0;

        if (cfg_we)
        begin
            case (cfg_index)
                REG_RISE_TAU: tau_next = cfg_wdata;
                REG_FALL_DUR: dur_next = cfg_wdata;
                default: ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    case (s_tuser)
                        OP_TARGET:
                        begin
                            hover_next = in_target;
                        end
                        OP_FALL:
                        begin
                            if (!any_raised_reg)
                            begin
                                fall_next = 1'b0;
                            end
                            else if (!in_animate)
                            begin
                                valid_clear     = 1'b1;
                                any_raised_next = 1'b0;
                                fall_next       = 1'b0;
                                hover_next      = '1;
                            end
                            else if (!fall_reg)
                            begin
                                fall_start_next = in_now;
                                fall_next       = 1'b1;
                                hover_next      = '1;
                                idx_next        = '0;
                                state_next      = S_COPY_RD;
                            end
                        end
                        OP_ROTATE:
                        begin
                            hover_next = '1;
                            if (active_reg >= CNT_W'(2))
                            begin
                                fwd_next   = in_forward;
                                idx_next   = in_forward ? '0 : active_reg - CNT_W'(1);
                                state_next = S_ROT_LOAD;
                            end
                        end
                        default:
                        begin
                            // Tick
                            if (in_count_clamp != active_reg)
                            begin
                                valid_clear     = 1'b1;
                                any_raised_next = 1'b0;
                                fall_next       = 1'b0;
                                active_next     = in_count_clamp;
                            end
                            if (in_count_clamp == '0)
                            begin
                                any_raised_next = 1'b0;
                                fall_next       = 1'b0;
                            end
                            else
                            begin
                                if (!seen_reg || tick_diff[31])
                                    dt_next = '0;
                                else if (tick_diff > {15'd0, DT_MAX_US})
                                    dt_next = DT_MAX_US;
                                else
                                    dt_next = tick_diff[DT_W-1:0];
                                prev_next    = in_now;
                                seen_next    = 1'b1;
                                now_next     = in_now;
                                anim_next    = in_animate;
                                count_next   = in_count_clamp;
                                idx_next     = '0;
                                any_acc_next = 1'b0;
                                state_next   = S_TICK;
                            end
                        end
                    endcase
                end
            end

            S_COPY_RD:
            begin
                rd_en      = 1'b1;
                state_next = S_COPY_WR;
            end
            S_COPY_WR:
            begin
                orig_we = 1'b1;
                orig_wd = lv;
                idx_next = idx_inc;
                state_next = (idx_reg == CNT_W'(MAX_SLOTS - 1)) ? S_IDLE : S_COPY_RD;
            end

            S_ROT_LOAD:
            begin
                rd_en      = 1'b1;
                state_next = S_ROT_KEEP;
            end
            S_ROT_KEEP:
            begin
                keep_l_next = lv;
                keep_o_next = orig_q_reg;
                state_next  = S_ROT_RD;
            end
            S_ROT_RD:
            begin
                if (idx_reg == rot_end)
                begin
                    state_next = S_ROT_END;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = rot_src[IDX_W-1:0];
                    state_next = S_ROT_WR;
                end
            end
            S_ROT_WR:
            begin
                lift_we    = 1'b1;
                orig_we    = 1'b1;
                idx_next   = rot_src;
                state_next = S_ROT_RD;
            end
            S_ROT_END:
            begin
                lift_we    = 1'b1;
                orig_we    = 1'b1;
                lift_wd    = keep_l_reg;
                orig_wd    = keep_o_reg;
                state_next = S_IDLE;
            end

            S_TICK:
            begin
                if (fall_reg)
                begin
                    if (dur_reg == '0)
                    begin
                        t_next     = LIFT_ONE;
                        state_next = S_S2;
                    end
                    else if (el[31])
                    begin
                        t_next     = '0;
                        state_next = S_S2;
                    end
                    else if (el >= {12'd0, dur_reg})
                    begin
                        t_next     = LIFT_ONE;
                        state_next = S_S2;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        div_num    = {12'd0, el[CFG_W-1:0], 16'd0};
                        div_den    = dur_reg;
                        state_next = S_TDIV;
                    end
                end
                else
                begin
                    if (!anim_reg || tau_reg == '0)
                    begin
                        k_next     = LIFT_ONE;
                        state_next = S_SLOT_RD;
                    end
                    else if (dt_reg == '0)
                    begin
                        k_next     = '0;
                        state_next = S_SLOT_RD;
                    end
                    else if ({8'd0, dt_reg} >= tau_x24)
                    begin
                        k_next     = LIFT_ONE;
                        state_next = S_SLOT_RD;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        div_num    = {7'd0, dt_reg, 24'd0};
                        div_den    = tau_reg;
                        state_next = S_UDIV;
                    end
                end
            end

            S_TDIV:
            begin
                if (!div_busy_reg)
                begin
                    t_next     = div_quo_reg[LIFT_W-1:0];
                    state_next = S_S2;
                end
            end
            S_S2:
            begin
                mul_a      = {15'd0, s_val};
                mul_b      = {15'd0, s_val};
                state_next = S_S2W;
            end
            S_S2W:
            begin
                s3_next    = step_m;
                state_next = S_S3;
            end
            S_S3:
            begin
                mul_a      = {15'd0, s3_reg};
                mul_b      = {15'd0, s_val};
                state_next = S_S3W;
            end
            S_S3W:
            begin
                s3_next    = step_m;
                state_next = S_SLOT_RD;
            end

            S_UDIV:
            begin
                if (!div_busy_reg)
                begin
                    u_next = div_quo_reg[31:0];
                    if (div_quo_reg == '0)
                    begin
                        k_next     = '0;
                        state_next = S_SLOT_RD;
                    end
                    else
                    begin
                        state_next = S_U2;
                    end
                end
            end
            S_U2:
            begin
                mul_a      = u_reg;
                mul_b      = u_reg;
                state_next = S_U2W;
            end
            S_U2W:
            begin
                u2_next    = mul_p_reg[63:32];
                state_next = S_U3;
            end
            S_U3:
            begin
                mul_a      = u2_reg;
                mul_b      = u_reg;
                state_next = S_U3W;
            end
            S_U3W:
            begin
                // The cube term is divided by six through its reciprocal.
                mul_a      = mul_p_reg[63:32];
                mul_b      = RECIP_6;
                state_next = S_QDIV;
            end
            S_QDIV:
            begin
                e_next      = e_init[31:0];
                sq_cnt_next = '0;
                state_next  = S_SQ;
            end
            S_SQ:
            begin
                mul_a      = e_reg;
                mul_b      = e_reg;
                state_next = S_SQW;
            end
            S_SQW:
            begin
                e_next      = e_new;
                sq_cnt_next = sq_cnt_reg + 3'd1;
                if (sq_cnt_reg == 3'(EXP_SQUARINGS - 1))
                begin
                    k_next     = k_sum[48:32];
                    state_next = S_SLOT_RD;
                end
                else
                begin
                    state_next = S_SQ;
                end
            end

            S_SLOT_RD:
            begin
                rd_en      = 1'b1;
                state_next = S_SLOT_MUL;
            end
            S_SLOT_MUL:
            begin
                if (fall_reg)
                begin
                    mul_a = {15'd0, orig_q_reg};
                    mul_b = {15'd0, s3_reg};
                end
                else
                begin
                    mul_a = {15'd0, rise_diff};
                    mul_b = {15'd0, k_reg};
                end
                l_next     = lv;
                state_next = S_SLOT_WR;
            end
            S_SLOT_WR:
            begin
                lift_we      = 1'b1;
                lift_wd      = slot_l;
                any_acc_next = any_acc_reg || slot_any;
                if (idx_inc == count_reg)
                begin
                    any_raised_next = any_acc_reg || slot_any;
                    if (fall_reg && t_reg >= LIFT_ONE)
                    begin
                        fall_next       = 1'b0;
                        any_raised_next = 1'b0;
                    end
                    idx_next   = '0;
                    state_next = S_EMIT_RD;
                end
                else
                begin
                    idx_next   = idx_inc;
                    state_next = S_SLOT_RD;
                end
            end

            S_EMIT_RD:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    rd_en      = 1'b1;
                    state_next = S_EMIT_WR;
                end
            end
            S_EMIT_WR:
            begin
                m_valid_next = 1'b1;
                m_data_next  = {fall_reg, any_raised_reg, lv, idx_reg[IDX_W-1:0]};
                m_last_next  = (idx_inc == count_reg);
                idx_next     = idx_inc;
                state_next   = (idx_inc == count_reg) ? S_IDLE : S_EMIT_RD;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        valid_next = valid_reg;
        if (valid_clear)
            valid_next = '0;
        if (lift_we)
            valid_next[wr_addr] = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            tau_reg        <= RISE_TAU_RESET;
            dur_reg        <= FALL_DUR_RESET;
            hover_reg      <= '1;
            active_reg     <= '0;
            any_raised_reg <= 1'b0;
            fall_reg       <= 1'b0;
            fall_start_reg <= '0;
            prev_reg       <= '0;
            seen_reg       <= 1'b0;
            valid_reg      <= '0;
            m_valid_reg    <= 1'b0;
            div_busy_reg   <= 1'b0;
            div_cnt_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            tau_reg        <= tau_next;
            dur_reg        <= dur_next;
            hover_reg      <= hover_next;
            active_reg     <= active_next;
            any_raised_reg <= any_raised_next;
            fall_reg       <= fall_next;
            fall_start_reg <= fall_start_next;
            prev_reg       <= prev_next;
            seen_reg       <= seen_next;
            valid_reg      <= valid_next;
            m_valid_reg    <= m_valid_next;
            if (div_start)
            begin
                div_busy_reg <= 1'b1;
                div_cnt_reg  <= DIVQ_W'(DIV_W);
            end
            else if (div_busy_reg)
            begin
                div_cnt_reg <= div_cnt_reg - DIVQ_W'(1);
                if (div_cnt_reg == DIVQ_W'(1))
                    div_busy_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        now_reg    <= now_next;
        anim_reg   <= anim_next;
        fwd_reg    <= fwd_next;
        count_reg  <= count_next;
        dt_reg     <= dt_next;
        t_reg      <= t_next;
        s3_reg     <= s3_next;
        u_reg      <= u_next;
        u2_reg     <= u2_next;
        e_reg      <= e_next;
        k_reg      <= k_next;
        sq_cnt_reg <= sq_cnt_next;
        idx_reg    <= idx_next;
        any_acc_reg <= any_acc_next;
        l_reg      <= l_next;
        keep_l_reg <= keep_l_next;
        keep_o_reg <= keep_o_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
        mul_p_reg  <= mul_a * mul_b;
        if (div_start)
        begin
            div_rem_reg <= '0;
            div_quo_reg <= div_num;
            div_den_reg <= div_den;
        end
        else if (div_busy_reg)
        begin
            div_rem_reg <= div_rem_next;
            div_quo_reg <= div_quo_next;
        end
    end

    // Lift memory; the valid bit of the entry is captured with the read data
    always_ff @(posedge clk)
    begin
        if (lift_we)
            lift_mem[wr_addr] <= lift_wd;
        if (rd_en)
        begin
            lift_q_reg  <= lift_mem[rd_addr];
            lift_qv_reg <= valid_reg[rd_addr];
        end
    end

    // Saved lifts for the fall
    always_ff @(posedge clk)
    begin
        if (orig_we)
            orig_mem[wr_addr] <= orig_wd;
        if (rd_en)
            orig_q_reg <= orig_mem[rd_addr];
    end

endmodule

// ===== rtl/slea_checker.sv =====
// ============================================================================
// slea_checker
// Port-level checks of the slot lift easing animator, bound to the top level.
// ============================================================================
module slea_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [slea_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                           m_tlast
);
    import slea_pkg::*;

    // A stalled result holds its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // Only the final result of a tick may appear while a command may be taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) && !m_tlast |-> !s_tready)
        else $error("result raised while idle");

    // A command transaction never produces a result on the very next edge.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !$rose(m_tvalid))
        else $error("result raised straight after a command");

    // Within a tick the next result follows with the next slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |-> ##2 (m_tvalid
            && m_tdata[IDX_W-1:0] == $past(m_tdata[IDX_W-1:0], 2) + IDX_W'(1)
            && m_tdata[M_TDATA_W-1] == $past(m_tdata[M_TDATA_W-1], 2)))
        else $error("slot sequence broken");

endmodule

bind slot_lift_easing_animator_core slea_checker u_slea_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
